### sv/assert_macros.svh
// Assertion macros shared by the battery gauge RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication or plain property holds at every rising clock edge
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/blgh_pkg.sv
// Package for the battery level gauge: transaction structs, config struct,
// band thresholds and register indexes. No dependencies.
`timescale 1ns / 1ps

package blgh_pkg;

    // Item kinds
    localparam logic KIND_READING = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_EMPTY_THRESHOLD   = 2'd0;
    localparam logic [1:0] CFG_RECOVER_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_LOW_CONFIRM_COUNT = 2'd2;
    localparam logic [1:0] CFG_CHARGE_TIME_CAP   = 2'd3;

    // Configuration reset values
    localparam logic [11:0] EMPTY_THRESHOLD_RST   = 12'd1135;
    localparam logic [11:0] RECOVER_THRESHOLD_RST = 12'd1550;
    localparam logic [3:0]  LOW_CONFIRM_COUNT_RST = 4'd10;
    localparam logic [15:0] CHARGE_TIME_CAP_RST   = 16'd600;

    // Levels
    localparam logic [3:0] LVL_EMPTY = 4'd0;
    localparam logic [3:0] LVL_1     = 4'd1;
    localparam logic [3:0] LVL_2     = 4'd2;
    localparam logic [3:0] LVL_3     = 4'd3;
    localparam logic [3:0] LVL_4     = 4'd4;
    localparam logic [3:0] LVL_5     = 4'd5;
    localparam logic [3:0] LVL_6     = 4'd6;
    localparam logic [3:0] LVL_7     = 4'd7;
    localparam logic [3:0] LVL_8     = 4'd8;
    localparam logic [3:0] LVL_9     = 4'd9;
    localparam logic [3:0] LVL_10    = 4'd10;

    // Offset thresholds (reading minus empty threshold)
    localparam logic [11:0] D_LVL10      = 12'd420;
    localparam logic [11:0] D_LVL9       = 12'd410;
    localparam logic [11:0] D_LVL8_FLOOR = 12'd395;
    localparam logic [11:0] D_LVL8_RISE  = 12'd400;
    localparam logic [11:0] D_LVL8_HOLD  = 12'd405;
    localparam logic [11:0] D_LVL9_PROMO = 12'd406;
    localparam logic [11:0] D_LVL7_FLOOR = 12'd380;
    localparam logic [11:0] D_LVL7_KEEP  = 12'd390;
    localparam logic [11:0] D_LVL6_FLOOR = 12'd345;
    localparam logic [11:0] D_LVL6_KEEP  = 12'd375;
    localparam logic [11:0] D_LVL5_FLOOR = 12'd305;
    localparam logic [11:0] D_LVL5_KEEP  = 12'd340;
    localparam logic [11:0] D_LVL4_FLOOR = 12'd240;
    localparam logic [11:0] D_LVL4_KEEP  = 12'd300;
    localparam logic [11:0] D_LVL3_FLOOR = 12'd200;
    localparam logic [11:0] D_LVL3_KEEP  = 12'd235;
    localparam logic [11:0] D_LVL2_FLOOR = 12'd100;
    localparam logic [11:0] D_LVL2_KEEP  = 12'd190;
    localparam logic [11:0] D_LVL1_KEEP  = 12'd90;

    // Flash confirmation counter
    localparam logic [3:0] FLASH_AT  = 4'd10;
    localparam logic [3:0] FLASH_MAX = 4'd11;

    localparam logic [15:0] CHARGE_MAX = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [11:0] sample;
        logic        running;
        logic        charging;
    } item_t;

    typedef struct packed {
        logic [3:0] level;
        logic       low_battery;
        logic       flash_request;
    } result_t;

    typedef struct packed {
        logic [11:0] empty_threshold;
        logic [11:0] recover_threshold;
        logic [3:0]  low_confirm_count;
        logic [15:0] charge_time_cap;
    } cfg_t;

    // Level and charge timer proposed by the quantizer
    typedef struct packed {
        logic [3:0]  level;
        logic [15:0] charge;
    } quant_t;

endpackage

### sv/blgh_quant.sv
// Offset quantizer with per-band hysteresis and level 8/9 charge timer rule.
// Depends on blgh_pkg.
`timescale 1ns / 1ps

module blgh_quant
    import blgh_pkg::*;
(
    input  logic [11:0] offset,
    input  logic [3:0]  level,
    input  logic [15:0] charge,
    input  logic [15:0] charge_time_cap,
    output quant_t      quant
);

    // Keep a higher level unless the offset dropped below the keep limit
    function automatic logic [3:0] band_level(input logic [3:0] cur, input logic [3:0] lvl,
                                              input logic below);
        logic [3:0] res;
        begin
            res = lvl;
            if (cur > lvl && !below)
            begin
                res = cur;
            end
            return res;
        end
    endfunction

    // Walk the bands from the top down
    always_comb
    begin
        quant.level  = level;
        quant.charge = charge;
        if (offset >= D_LVL10)
        begin
            quant.level = LVL_10;
        end
        else if (offset >= D_LVL9)
        begin
            quant.level = LVL_9;
        end
        else if (offset > D_LVL8_FLOOR)
        begin
            if (level < LVL_8)
            begin
                if (offset > D_LVL8_RISE)
                begin
                    quant.level = LVL_8;
                end
            end
            else if (charge == '0 && offset < D_LVL8_HOLD)
            begin
                quant.level = LVL_8;
            end
            // Promote a level stuck at 8 once the charge timer passes the cap
            if (charge != '0 && offset > D_LVL9_PROMO && charge > charge_time_cap)
            begin
                quant.charge = charge_time_cap;
                quant.level  = LVL_9;
            end
        end
        else if (offset > D_LVL7_FLOOR)
        begin
            quant.level  = band_level(level, LVL_7, offset < D_LVL7_KEEP);
            quant.charge = '0;
        end
        else if (offset > D_LVL6_FLOOR)
        begin
            quant.level  = band_level(level, LVL_6, offset < D_LVL6_KEEP);
            quant.charge = '0;
        end
        else if (offset > D_LVL5_FLOOR)
        begin
            quant.level  = band_level(level, LVL_5, offset < D_LVL5_KEEP);
            quant.charge = '0;
        end
        else if (offset > D_LVL4_FLOOR)
        begin
            quant.level  = band_level(level, LVL_4, offset < D_LVL4_KEEP);
            quant.charge = '0;
        end
        else if (offset > D_LVL3_FLOOR)
        begin
            quant.level  = band_level(level, LVL_3, offset < D_LVL3_KEEP);
            quant.charge = '0;
        end
        else if (offset > D_LVL2_FLOOR)
        begin
            quant.level  = band_level(level, LVL_2, offset < D_LVL2_KEEP);
            quant.charge = '0;
        end
        else if (offset != '0)
        begin
            quant.level  = band_level(level, LVL_1, offset < D_LVL1_KEEP);
            quant.charge = '0;
        end
    end

endmodule

### sv/blgh_state.sv
// Gauge state (level, low/flash counters, charge timer) and per-item update.
// Depends on blgh_pkg, blgh_quant and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module blgh_state
    import blgh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [3:0]  level_reg, level_next;
    logic [3:0]  low_counter_reg, low_counter_next;
    logic [3:0]  flash_counter_reg, flash_counter_next;
    logic [15:0] charge_reg, charge_next;

    logic [3:0]  confirm;
    logic [4:0]  low_inc;
    logic [3:0]  flash_inc;
    logic [3:0]  flash_cnt;
    logic        flash;
    logic        above_recover;
    logic        below_empty;
    logic [11:0] offset;
    quant_t      quant;

    // Treat a zero confirm count as one
    assign confirm = (cfg.low_confirm_count == '0) ? 4'd1 : cfg.low_confirm_count;

    assign above_recover = item.sample > cfg.recover_threshold;
    assign below_empty   = item.sample < cfg.empty_threshold;
    assign offset        = below_empty ? '0 : item.sample - cfg.empty_threshold;
    assign low_inc       = {1'b0, low_counter_reg} + 5'd1;
    assign flash_inc     = flash_counter_reg + 4'd1;

    blgh_quant u_quant (
        .offset          (offset),
        .level           (level_reg),
        .charge          (charge_reg),
        .charge_time_cap (cfg.charge_time_cap),
        .quant           (quant)
    );

    // Work out the next state for the current item
    always_comb
    begin
        level_next         = level_reg;
        low_counter_next   = low_counter_reg;
        flash_counter_next = flash_counter_reg;
        charge_next        = charge_reg;
        flash              = 1'b0;
        flash_cnt          = flash_counter_reg;
        if (item.kind == KIND_TICK)
        begin
            // Count charge time at level 8, drop it when unplugged
            if (item.charging)
            begin
                if (level_reg == LVL_8 && charge_reg != CHARGE_MAX)
                begin
                    charge_next = charge_reg + 16'd1;
                end
            end
            else
            begin
                charge_next = '0;
            end
        end
        else if (above_recover)
        begin
            low_counter_next = '0;
            level_next       = quant.level;
            charge_next      = quant.charge;
        end
        else if (below_empty)
        begin
            if (low_inc < {1'b0, confirm})
            begin
                low_counter_next = low_inc[3:0];
            end
            else
            begin
                // Low battery confirmed: force empty and, while running, advance flash count
                low_counter_next = confirm;
                level_next       = LVL_EMPTY;
                if (item.running)
                begin
                    flash_cnt = flash_inc;
                    flash     = (flash_inc == FLASH_AT);
                end
                flash_counter_next = (flash_cnt > FLASH_MAX) ? FLASH_MAX : flash_cnt;
            end
        end
        else
        begin
            low_counter_next   = '0;
            flash_counter_next = '0;
            level_next         = quant.level;
            charge_next        = quant.charge;
        end
    end

    assign result.level         = level_next;
    assign result.low_battery   = (low_counter_next != '0) && (low_counter_next >= confirm);
    assign result.flash_request = flash;

    // Hold state, advance on each processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg         <= LVL_EMPTY;
            low_counter_reg   <= '0;
            flash_counter_reg <= '0;
            charge_reg        <= '0;
        end
        else if (step)
        begin
            level_reg         <= level_next;
            low_counter_reg   <= low_counter_next;
            flash_counter_reg <= flash_counter_next;
            charge_reg        <= charge_next;
        end
    end

    `ASSERT_NEVER(a_level_range, level_reg > LVL_10, "level register above 10")
    `ASSERT_NEVER(a_flash_sat, flash_counter_reg > FLASH_MAX, "flash counter past saturation")
    `ASSERT_CLK(a_flash_low, step && result.flash_request |-> result.low_battery && result.level == LVL_EMPTY, "flash request without confirmed low battery")
    `ASSERT_CLK(a_tick_level, step && item.kind == KIND_TICK |=> level_reg == $past(level_reg), "tick changed the level")

endmodule

### sv/battery_level_gauge_hysteresis.sv
// Battery level gauge: one transaction per clock cycle on the item channel while the
// result side keeps up; a held-off result_ready stalls it. Each item passes the input
// register, then the result register, before its result can be taken.
// The rate is set by the update of the level/counter/timer state, which
// each item reads and writes in the cycle it leaves the input register. The result
// register lets a new item enter while a finished result waits to be taken. The
// configuration port is always ready; write it only while no item is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module battery_level_gauge_hysteresis
    import blgh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic    stage_valid_reg;
    item_t   stage_item_reg;
    logic    result_valid_reg;
    result_t result_reg;
    cfg_t    cfg_reg;
    logic    advance;
    result_t step_result;

    // Move the staged item into the result register when that slot frees up
    assign advance      = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !stage_valid_reg || advance;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    blgh_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (stage_item_reg),
        .cfg    (cfg_reg),
        .result (step_result)
    );

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.empty_threshold   <= EMPTY_THRESHOLD_RST;
            cfg_reg.recover_threshold <= RECOVER_THRESHOLD_RST;
            cfg_reg.low_confirm_count <= LOW_CONFIRM_COUNT_RST;
            cfg_reg.charge_time_cap   <= CHARGE_TIME_CAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_EMPTY_THRESHOLD:   cfg_reg.empty_threshold   <= cfg_data[11:0];
                CFG_RECOVER_THRESHOLD: cfg_reg.recover_threshold <= cfg_data[11:0];
                CFG_LOW_CONFIRM_COUNT: cfg_reg.low_confirm_count <= cfg_data[3:0];
                CFG_CHARGE_TIME_CAP:   cfg_reg.charge_time_cap   <= cfg_data;
                default:               cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Input register: take a transaction whenever the stage empties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_item_reg <= item;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    `ASSERT_CLK(a_empty_ready, !stage_valid_reg |-> item_ready, "empty stage not ready")
    `ASSERT_CLK(a_accept_staged, item_valid && item_ready |=> stage_valid_reg, "item not staged")
    `ASSERT_CLK(a_advance_result, advance |=> result_valid_reg, "no result after advance")

endmodule

### sim/battery_level_gauge_hysteresis_tb.sv
// Self-checking testbench for battery_level_gauge_hysteresis: a level tracker class
// predicts each result, plain tasks drive the item, result and config channels.
// Depends on blgh_pkg and the battery_level_gauge_hysteresis RTL.
`timescale 1ns / 1ps

import blgh_pkg::*;

// Track level, low counter, flash counter and charge timer; queue expected results
class level_tracker;
    logic [11:0] empty_th;
    logic [11:0] recover_th;
    logic [3:0]  confirm_cfg;
    logic [15:0] charge_cap;
    logic [3:0]  lvl;
    logic [3:0]  low_cnt;
    logic [3:0]  flash_cnt;
    logic [15:0] chg_sec;
    result_t     expected_levels[$];
    int          errors;
    int          shown;

    function new();
        empty_th    = EMPTY_THRESHOLD_RST;
        recover_th  = RECOVER_THRESHOLD_RST;
        confirm_cfg = LOW_CONFIRM_COUNT_RST;
        charge_cap  = CHARGE_TIME_CAP_RST;
        lvl         = LVL_EMPTY;
        low_cnt     = '0;
        flash_cnt   = '0;
        chg_sec     = '0;
        errors      = 0;
        shown       = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            CFG_EMPTY_THRESHOLD:   empty_th    = val[11:0];
            CFG_RECOVER_THRESHOLD: recover_th  = val[11:0];
            CFG_LOW_CONFIRM_COUNT: confirm_cfg = val[3:0];
            CFG_CHARGE_TIME_CAP:   charge_cap  = val;
            default: ;
        endcase
    endfunction

    // A confirm count of zero behaves as one
    function int confirm_needed();
        return (confirm_cfg == 0) ? 1 : int'(confirm_cfg);
    endfunction

    function int pending();
        return expected_levels.size();
    endfunction

    // Keep a higher level unless the offset drops below the band's keep point
    function void settle_band(int d, logic [3:0] band_lvl, int keep);
        if (lvl > band_lvl) begin
            if (d < keep)
                lvl = band_lvl;
        end
        else
            lvl = band_lvl;
        chg_sec = '0;
    endfunction

    function void quantize(int d);
        if (d >= D_LVL10)
            lvl = LVL_10;
        else if (d >= D_LVL9)
            lvl = LVL_9;
        else if (d > D_LVL8_FLOOR)
        begin
            if (lvl < LVL_8) begin
                if (d > D_LVL8_RISE)
                    lvl = LVL_8;
            end
            else if (chg_sec == 0 && d < D_LVL8_HOLD)
                lvl = LVL_8;
            // Promote a level stuck at 8 once the charge timer passes the cap
            if (chg_sec > 0 && d > D_LVL9_PROMO && chg_sec > charge_cap) begin
                chg_sec = charge_cap;
                lvl     = LVL_9;
            end
        end
        else if (d > D_LVL7_FLOOR) settle_band(d, LVL_7, int'(D_LVL7_KEEP));
        else if (d > D_LVL6_FLOOR) settle_band(d, LVL_6, int'(D_LVL6_KEEP));
        else if (d > D_LVL5_FLOOR) settle_band(d, LVL_5, int'(D_LVL5_KEEP));
        else if (d > D_LVL4_FLOOR) settle_band(d, LVL_4, int'(D_LVL4_KEEP));
        else if (d > D_LVL3_FLOOR) settle_band(d, LVL_3, int'(D_LVL3_KEEP));
        else if (d > D_LVL2_FLOOR) settle_band(d, LVL_2, int'(D_LVL2_KEEP));
        else if (d > 0)            settle_band(d, LVL_1, int'(D_LVL1_KEEP));
    endfunction

    // Advance the state for one accepted item and queue its result
    function void take_item(item_t it);
        result_t r;
        int      conf;
        int      cnt;
        logic    flash;
        conf  = confirm_needed();
        flash = 1'b0;
        if (it.kind == KIND_TICK) begin
            if (it.charging) begin
                if (lvl == LVL_8 && chg_sec != CHARGE_MAX)
                    chg_sec = chg_sec + 16'd1;
            end
            else
                chg_sec = '0;
        end
        else if (it.sample > recover_th) begin
            low_cnt = '0;
            // Misordered thresholds give an offset of zero
            quantize((it.sample >= empty_th) ? int'(it.sample) - int'(empty_th) : 0);
        end
        else if (it.sample < empty_th) begin
            cnt = int'(low_cnt) + 1;
            if (cnt < conf)
                low_cnt = cnt[3:0];
            else begin
                low_cnt = conf[3:0];
                lvl     = LVL_EMPTY;
                if (it.running) begin
                    flash_cnt = flash_cnt + 4'd1;
                    if (flash_cnt == FLASH_AT)
                        flash = 1'b1;
                end
                if (flash_cnt > FLASH_MAX)
                    flash_cnt = FLASH_MAX;
            end
        end
        else begin
            low_cnt   = '0;
            flash_cnt = '0;
            quantize(int'(it.sample) - int'(empty_th));
        end
        r.level         = lvl;
        r.low_battery   = (low_cnt != 0 && int'(low_cnt) >= conf);
        r.flash_request = flash;
        expected_levels.push_back(r);
    endfunction

    function void report(string field, int exp_val, int got_val);
        errors++;
        // Hold the log to a readable size when the block is badly off
        if (shown < 60) begin
            shown++;
            $display("t=%0t %s mismatch: expected %0d, got %0d", $time, field, exp_val,
                     got_val);
        end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void match_result(result_t got);
        result_t exp_r;
        if (expected_levels.size() == 0) begin
            errors++;
            $display("t=%0t unexpected result: expected none, got level %0d", $time,
                     got.level);
            return;
        end
        exp_r = expected_levels.pop_front();
        if (got.level !== exp_r.level)
            report("level", int'(exp_r.level), int'(got.level));
        if (got.low_battery !== exp_r.low_battery)
            report("low_battery", int'(exp_r.low_battery), int'(got.low_battery));
        if (got.flash_request !== exp_r.flash_request)
            report("flash_request", int'(exp_r.flash_request), int'(got.flash_request));
    endfunction
endclass

module battery_level_gauge_hysteresis_tb;

    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_ITEMS = 650;
    localparam int BURST_TICKS  = 24;
    localparam int EDGES[19] = '{int'(D_LVL1_KEEP), int'(D_LVL2_FLOOR), int'(D_LVL2_KEEP),
                                 int'(D_LVL3_FLOOR), int'(D_LVL3_KEEP), int'(D_LVL4_FLOOR),
                                 int'(D_LVL4_KEEP), int'(D_LVL5_FLOOR), int'(D_LVL5_KEEP),
                                 int'(D_LVL6_FLOOR), int'(D_LVL6_KEEP), int'(D_LVL7_FLOOR),
                                 int'(D_LVL7_KEEP), int'(D_LVL8_FLOOR), int'(D_LVL8_RISE),
                                 int'(D_LVL8_HOLD), int'(D_LVL9_PROMO), int'(D_LVL9),
                                 int'(D_LVL10)};

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    level_tracker tracker;
    bit           quiet;
    bit           hold_req;
    int           items_sent;
    int           cycles;
    int           phase;
    int           target;
    cfg_t         cfg;

    battery_level_gauge_hysteresis u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic item_t reading(int s, bit run);
        item_t it;
        it.kind     = KIND_READING;
        it.sample   = s[11:0];
        it.running  = run;
        it.charging = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic item_t tick(bit charging);
        item_t it;
        it.kind     = KIND_TICK;
        it.sample   = 12'($urandom_range(0, 4095));
        it.running  = 1'($urandom_range(0, 1));
        it.charging = charging;
        return it;
    endfunction

    function automatic item_t noise();
        item_t it;
        it.kind     = 1'($urandom_range(0, 1));
        it.sample   = 12'($urandom_range(0, 4095));
        it.running  = 1'($urandom_range(0, 1));
        it.charging = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic cfg_t make_cfg(int e, int r, int c, int cap);
        cfg_t k;
        k.empty_threshold   = e[11:0];
        k.recover_threshold = r[11:0];
        k.low_confirm_count = c[3:0];
        k.charge_time_cap   = cap[15:0];
        return k;
    endfunction

    // Extremes often, ordered thresholds usually, a small cap most of the time
    function automatic cfg_t pick_cfg();
        int e;
        int r;
        int c;
        int cap;
        case ($urandom_range(0, 5))
            0:       e = 0;
            1:       e = 4095;
            2:       e = int'(EMPTY_THRESHOLD_RST);
            default: e = $urandom_range(0, 3600);
        endcase
        case ($urandom_range(0, 5))
            0:       r = 0;
            1:       r = 4095;
            2:       r = $urandom_range(0, 4095);
            default: r = (e + $urandom_range(0, 450) > 4095) ? 4095 : e + $urandom_range(0, 450);
        endcase
        case ($urandom_range(0, 4))
            0:       c = 0;
            1:       c = 1;
            2:       c = 15;
            default: c = $urandom_range(0, 15);
        endcase
        case ($urandom_range(0, 5))
            0:       cap = 0;
            1:       cap = 65535;
            2:       cap = $urandom_range(0, 65535);
            default: cap = $urandom_range(0, 8);
        endcase
        return make_cfg(e, r, c, cap);
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_item(input item_t it);
        int gap;
        gap = quiet ? 0 : idle_len();
        @(negedge clk);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        tracker.take_item(it);
        items_sent++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_reg(idx, val);
    endtask

    task automatic program_cfg(input cfg_t k);
        write_reg(CFG_EMPTY_THRESHOLD, {4'd0, k.empty_threshold});
        write_reg(CFG_RECOVER_THRESHOLD, {4'd0, k.recover_threshold});
        write_reg(CFG_LOW_CONFIRM_COUNT, {12'd0, k.low_confirm_count});
        write_reg(CFG_CHARGE_TIME_CAP, k.charge_time_cap);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random walk of offsets across the bands, sometimes right at a band edge
    task automatic walk_levels();
        int d;
        int top;
        int steps;
        top   = 4095 - int'(tracker.empty_th);
        d     = $urandom_range(0, (top < 440) ? top : 440);
        steps = $urandom_range(3, 12);
        repeat (steps) begin
            send_item(reading(int'(tracker.empty_th) + d, 1'($urandom_range(0, 1))));
            if ($urandom_range(0, 2) == 0)
                d = EDGES[$urandom_range(0, 18)] + $urandom_range(0, 2) - 1;
            else
                d = d + $urandom_range(0, 60) - 30;
            if (d < 0)
                d = 0;
            if (d > top)
                d = top;
        end
    endtask

    // Enter level 8, count charge seconds, then read around the hold band
    task automatic charge_cycle();
        int k;
        int base;
        if (4095 - int'(tracker.empty_th) < 420) begin
            walk_levels();
            return;
        end
        base = int'(tracker.empty_th);
        send_item(reading(base + $urandom_range(401, 404), 1'($urandom_range(0, 1))));
        k = $urandom_range(0, 10);
        repeat (k) send_item(tick($urandom_range(0, 7) != 0));
        send_item(reading(base + $urandom_range(396, 412), 1'($urandom_range(0, 1))));
    endtask

    // Run of low readings, often long enough to confirm and to reach the flash point
    task automatic low_run();
        int n;
        bit run;
        if (tracker.empty_th == 0) begin
            send_item(noise());
            return;
        end
        n   = $urandom_range(1, tracker.confirm_needed() + 14);
        run = ($urandom_range(0, 9) != 0);
        repeat (n)
            send_item(reading($urandom_range(0, int'(tracker.empty_th) - 1),
                              run || ($urandom_range(0, 3) == 0)));
    endtask

    // Accept results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.match_result(result);
    end

    // Drive result_ready: random stalls, quiet stretches, one long hold-off
    always
    begin : ready_drive
        int stall;
        @(negedge clk);
        if (hold_req) begin
            result_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_req = 1'b0;
            result_ready <= 1'b1;
        end
        else if (quiet)
            result_ready <= 1'b1;
        else begin
            stall = idle_len();
            if (stall > 0) begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("battery_level_gauge_hysteresis_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        tracker      = new();
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_EMPTY_THRESHOLD;
        cfg_data     = '0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        items_sent   = 0;
        cycles       = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pass at reset settings: top, bands, zero offset, level 8 charge,
        // recover boundary, ticks, then a confirmed low run while running
        send_item(reading(4095, 1'b1));
        send_item(reading(1530, 1'b0));
        send_item(reading(1235, 1'b0));
        send_item(reading(1185, 1'b0));
        send_item(reading(1135, 1'b0));
        send_item(reading(1536, 1'b0));
        send_item(tick(1'b1));
        send_item(tick(1'b1));
        send_item(reading(1542, 1'b0));
        send_item(reading(1551, 1'b0));
        send_item(reading(1550, 1'b0));
        send_item(tick(1'b0));
        send_item(tick(1'b1));
        send_item(reading(1134, 1'b1));
        repeat (9) send_item(reading(0, 1'b1));
        send_item(reading(1135, 1'b1));
        send_item(reading(4095, 1'b0));

        // Random phases, the first two at fixed register extremes
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            if (phase == 0)
                cfg = make_cfg(0, 4095, 0, 0);
            else if (phase == 1)
                cfg = make_cfg(4095, 0, 15, 65535);
            else if (phase == 2)
                cfg = make_cfg(int'(EMPTY_THRESHOLD_RST), int'(RECOVER_THRESHOLD_RST), 1, 3);
            else
                cfg = pick_cfg();
            program_cfg(cfg);
            quiet = ($urandom_range(0, 3) == 0);
            // Stall the receiver for a long stretch while items keep coming
            if (phase == 3) begin
                quiet    = 1'b1;
                hold_req = 1'b1;
            end
            target = items_sent + $urandom_range(40, 90);
            while (items_sent < target) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: walk_levels();
                    3, 4:    charge_cycle();
                    5, 6:    low_run();
                    default: repeat ($urandom_range(1, 4)) send_item(noise());
                endcase
            end
            phase++;
        end

        // Level 8, an unbroken run of charging ticks past a small cap, then promotion
        settle();
        program_cfg(make_cfg(int'(EMPTY_THRESHOLD_RST), int'(RECOVER_THRESHOLD_RST),
                             int'(LOW_CONFIRM_COUNT_RST), 5));
        quiet = 1'b1;
        send_item(reading(EMPTY_THRESHOLD_RST + 50, 1'b0));
        send_item(reading(EMPTY_THRESHOLD_RST + 402, 1'b0));
        repeat (BURST_TICKS) send_item(tick(1'b1));
        send_item(reading(EMPTY_THRESHOLD_RST + 407, 1'b0));
        settle();
        repeat (10) @(posedge clk);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("battery_level_gauge_hysteresis_tb: done, clean");
        else
            $display("battery_level_gauge_hysteresis_tb: done, errors");
        $finish;
    end

endmodule
